// ===== rtl/xorshift_range_generator_top_macros.svh =====
// assertion macros for the checker file
`ifndef XORSHIFT_RANGE_GENERATOR_TOP_MACROS_SVH
`define XORSHIFT_RANGE_GENERATOR_TOP_MACROS_SVH

// checked only outside reset
`define XRG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// checked at every edge, reset included
`define XRG_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/xrg_pkg.sv =====
// shared types, constants and generator step functions
package xrg_pkg;

  localparam int unsigned NARROW_W = 32;
  localparam int unsigned WIDE_W = 64;
  localparam int unsigned FUNC_W = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CNT_W = $clog2(WIDE_W + 1);
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [NARROW_W-1:0] NARROW_SEED_RESET = 32'd2463534242;
  localparam logic [WIDE_W-1:0] WIDE_SEED_RESET = 64'd88172645463325252;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_RAW32   = 2'd0,
    FUNC_RANGE32 = 2'd1,
    FUNC_RAW64   = 2'd2,
    FUNC_RANGE64 = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEED_NARROW = 2'd0,
    REG_SEED_WIDE   = 2'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_SUM
  } back_state_t;

  typedef struct packed {
    logic              narrow;
    logic              divide;
    logic              span_zero;
    logic [WIDE_W-1:0] lo;
    logic [WIDE_W-1:0] word;
    logic [WIDE_W-1:0] span;
  } entry_t;

  function automatic logic [NARROW_W-1:0] step_narrow(input logic [NARROW_W-1:0] s);
    logic [NARROW_W-1:0] x;
    x = s;
    x = x ^ (x << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    return x;
  endfunction

  function automatic logic [WIDE_W-1:0] step_wide(input logic [WIDE_W-1:0] s);
    logic [WIDE_W-1:0] x;
    x = s;
    x = x ^ (x << 13);
    x = x ^ (x >> 7);
    x = x ^ (x << 17);
    return x;
  endfunction

endpackage

// ===== rtl/xorshift_range_generator_top.sv =====
// top level of the xorshift range generator
//
// request channel: in_valid/in_stall with func, range_min, range_max; a
// request is taken at an edge with in_valid high and in_stall low
// result channel: out_valid/out_stall with value and span_zero, one result
// per request, in request order
// seed writes: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high; index 0 loads the 32-bit generator, index 1 the 64-bit one
// the front steps the generator in the cycle a request is taken and queues it
// a taken request waits in the queue until the idle back end pops it; raw
// requests and wrapped spans go straight to the range offset, ranged ones
// first pass the one-bit-per-cycle remainder loop in the back end
// the back end works on one request at a time; the queue lets the front
// keep taking requests while the back is busy or the output waits
// reset loads both generators with their default seeds and empties the queue
// while out_stall is high the result holds and the queue fills, then
// in_stall rises
module xorshift_range_generator_top #(
  parameter int unsigned QUEUE_DEPTH = xrg_pkg::QUEUE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [xrg_pkg::FUNC_W-1:0]          func,
  input  logic signed [xrg_pkg::WIDE_W-1:0]   range_min,
  input  logic signed [xrg_pkg::WIDE_W-1:0]   range_max,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [xrg_pkg::WIDE_W-1:0]          value,
  output logic                                span_zero,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [xrg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [xrg_pkg::WIDE_W-1:0]          cfg_data
);

  logic            q_full;
  logic            q_empty;
  logic            push;
  logic            pop;
  xrg_pkg::entry_t push_entry;
  xrg_pkg::entry_t pop_entry;

  xrg_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .func       (func),
    .range_min  (range_min),
    .range_max  (range_max),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  xrg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .empty      (q_empty),
    .pop_entry  (pop_entry)
  );

  xrg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_entry   (pop_entry),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value     (value),
    .span_zero (span_zero)
  );

endmodule

// ===== rtl/xrg_front.sv =====
// front end: request intake, generator state, seed writes and span setup
module xrg_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [xrg_pkg::FUNC_W-1:0]          func,
  input  logic signed [xrg_pkg::WIDE_W-1:0]   range_min,
  input  logic signed [xrg_pkg::WIDE_W-1:0]   range_max,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [xrg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [xrg_pkg::WIDE_W-1:0]          cfg_data,
  input  logic                                q_full,
  output logic                                push,
  output xrg_pkg::entry_t                     push_entry
);

  logic [xrg_pkg::NARROW_W-1:0] narrow_state;
  logic [xrg_pkg::WIDE_W-1:0]   wide_state;
  logic [xrg_pkg::NARROW_W-1:0] narrow_word;
  logic [xrg_pkg::WIDE_W-1:0]   wide_word;
  logic [xrg_pkg::NARROW_W-1:0] span_n;
  logic [xrg_pkg::WIDE_W-1:0]   span_w;
  logic                         cfg_write;

  assign in_stall  = q_full;
  assign cfg_ready = 1'b1;
  assign push      = in_valid && !q_full;
  assign cfg_write = cfg_valid && cfg_ready;

  assign narrow_word = xrg_pkg::step_narrow(narrow_state);
  assign wide_word   = xrg_pkg::step_wide(wide_state);
  assign span_n = range_max[xrg_pkg::NARROW_W-1:0] + 32'd1 - range_min[xrg_pkg::NARROW_W-1:0];
  assign span_w = range_max + 64'd1 - range_min;

  always_comb begin
    push_entry = '0;
    unique case (xrg_pkg::func_t'(func))
      xrg_pkg::FUNC_RAW32: begin
        push_entry.narrow = 1'b1;
        push_entry.word   = {32'd0, narrow_word};
      end
      xrg_pkg::FUNC_RANGE32: begin
        push_entry.narrow    = 1'b1;
        push_entry.word      = {32'd0, narrow_word};
        push_entry.lo        = {32'd0, range_min[xrg_pkg::NARROW_W-1:0]};
        push_entry.span      = {32'd0, span_n};
        push_entry.span_zero = (span_n == '0);
        push_entry.divide    = (span_n != '0);
      end
      xrg_pkg::FUNC_RAW64: begin
        push_entry.word = wide_word;
      end
      xrg_pkg::FUNC_RANGE64: begin
        push_entry.word      = wide_word;
        push_entry.lo        = range_min;
        push_entry.span      = span_w;
        push_entry.span_zero = (span_w == '0);
        push_entry.divide    = (span_w != '0);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      narrow_state <= xrg_pkg::NARROW_SEED_RESET;
      wide_state   <= xrg_pkg::WIDE_SEED_RESET;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          xrg_pkg::REG_SEED_NARROW: narrow_state <= cfg_data[xrg_pkg::NARROW_W-1:0];
          xrg_pkg::REG_SEED_WIDE:   wide_state <= cfg_data;
          default: ;
        endcase
      end
      if (push) begin
        if (func == xrg_pkg::FUNC_RAW32 || func == xrg_pkg::FUNC_RANGE32) begin
          narrow_state <= narrow_word;
        end else begin
          wide_state <= wide_word;
        end
      end
    end
  end

endmodule

// ===== rtl/xrg_queue.sv =====
// short request queue between front and back
module xrg_queue #(
  parameter int unsigned DEPTH = xrg_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  xrg_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output xrg_pkg::entry_t pop_entry
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  xrg_pkg::entry_t  entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full      = (count == CNT_W'(DEPTH));
  assign empty     = (count == '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign pop_entry = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/xrg_back.sv =====
// back end: shift-subtract remainder, range offset and output register
module xrg_back (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 q_empty,
  input  xrg_pkg::entry_t                      q_entry,
  output logic                                 pop,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [xrg_pkg::WIDE_W-1:0]           value,
  output logic                                 span_zero
);

  xrg_pkg::back_state_t        state;
  xrg_pkg::back_state_t        state_next;
  logic                        narrow;
  logic                        zero_flag;
  logic [xrg_pkg::WIDE_W-1:0]  lo;
  logic [xrg_pkg::WIDE_W-1:0]  span;
  logic [xrg_pkg::WIDE_W-1:0]  dvd;
  logic [xrg_pkg::WIDE_W-1:0]  rem;
  logic [xrg_pkg::CNT_W-1:0]   cnt;
  logic [xrg_pkg::WIDE_W:0]    rem_sh;
  logic [xrg_pkg::WIDE_W:0]    diff;
  logic [xrg_pkg::WIDE_W-1:0]  sum;
  logic                        out_free;
  logic                        load_out;

  assign rem_sh   = {rem, dvd[xrg_pkg::WIDE_W-1]};
  assign diff     = rem_sh - {1'b0, span};
  assign out_free = !out_valid || !out_stall;
  assign sum = narrow ? {32'd0, lo[xrg_pkg::NARROW_W-1:0] + rem[xrg_pkg::NARROW_W-1:0]}
                      : lo + rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= xrg_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      xrg_pkg::B_IDLE: begin
        if (!q_empty) begin
          pop        = 1'b1;
          state_next = q_entry.divide ? xrg_pkg::B_DIV : xrg_pkg::B_SUM;
        end
      end
      xrg_pkg::B_DIV: begin
        if (cnt == xrg_pkg::CNT_W'(1)) begin
          state_next = xrg_pkg::B_SUM;
        end
      end
      xrg_pkg::B_SUM: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = xrg_pkg::B_IDLE;
        end
      end
      default: state_next = xrg_pkg::B_IDLE;
    endcase
  end

  // divider datapath
  always_ff @(posedge clk) begin
    if (pop) begin
      narrow    <= q_entry.narrow;
      zero_flag <= q_entry.span_zero;
      lo        <= q_entry.lo;
      span      <= q_entry.span;
      if (q_entry.divide) begin
        rem <= '0;
        dvd <= q_entry.narrow ? {q_entry.word[xrg_pkg::NARROW_W-1:0], 32'd0} : q_entry.word;
        cnt <= q_entry.narrow ? xrg_pkg::CNT_W'(xrg_pkg::NARROW_W)
                              : xrg_pkg::CNT_W'(xrg_pkg::WIDE_W);
      end else begin
        rem <= q_entry.word;
        dvd <= '0;
        cnt <= '0;
      end
    end else if (state == xrg_pkg::B_DIV) begin
      rem <= diff[xrg_pkg::WIDE_W] ? rem_sh[xrg_pkg::WIDE_W-1:0] : diff[xrg_pkg::WIDE_W-1:0];
      dvd <= {dvd[xrg_pkg::WIDE_W-2:0], 1'b0};
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      value     <= sum;
      span_zero <= zero_flag;
    end
  end

endmodule

// ===== rtl/xrg_checker.sv =====
// port-level checker for the xorshift range generator, with its bind
`include "xorshift_range_generator_top_macros.svh"

module xrg_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [xrg_pkg::WIDE_W-1:0]    value,
  input logic                          span_zero
);

  `XRG_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result dropped under stall")
  `XRG_ASSERT(a_value_stable, out_valid && out_stall |=> $stable(value), "value changed")
  `XRG_ASSERT(a_flag_stable, out_valid && out_stall |=> $stable(span_zero), "flag changed")
  `XRG_ASSERT_ALWAYS(a_reset_out, $past(rst) |-> !out_valid, "result shown right after reset")
  `XRG_ASSERT_ALWAYS(a_reset_in, $past(rst) |-> !in_stall, "request stalled after reset")

endmodule

bind xorshift_range_generator_top xrg_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .value     (value),
  .span_zero (span_zero)
);
